// ===== rtl/spq_pkg.sv =====
// shared types and codes for the sorted priority queue
`default_nettype none
package spq_pkg;

	// action codes
	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic               action;
		logic signed [31:0] value;
		logic signed [15:0] priority_req;
	} spq_in_t;

	typedef struct packed {
		logic               head_valid;
		logic signed [31:0] head_value;
		logic signed [15:0] head_priority;
		logic [1:0]         status;
		logic [7:0]         count;
	} spq_out_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} spq_entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic enq;
		logic deq;
	} spq_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/spq_cell.sv =====
// one storage cell of the sorted chain: compare with the new word, shift or load
`default_nettype none
module spq_cell
	import spq_pkg::*;
(
	input  wire logic       clk,
	input  wire spq_ctrl_t  ctrl,
	input  wire logic       occupied,
	input  wire spq_entry_t new_entry,
	input  wire spq_entry_t prev_entry,
	input  wire logic       prev_shift,
	input  wire spq_entry_t next_entry,
	output logic            shift,
	output spq_entry_t      entry
);

	spq_entry_t entry_q;

	// empty cells count as holding a larger priority
	assign shift = !occupied || (entry_q.prio > new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (shift) begin
				entry_q <= prev_shift ? prev_entry : new_entry;
			end
		end else if (ctrl.deq) begin
			entry_q <= next_entry;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sorted_priority_queue_top.sv =====
// sorted priority queue top level: chain of compare-and-shift cells plus count
`default_nettype none
// the result word appears with done in the cycle after start is taken
// throughput: one word per cycle, every cell compares and shifts in the same cycle
// busy stays low, the receiver cannot stall and needs no back pressure
// reset clears the entry count and done; cell contents need no reset
module sorted_priority_queue_top
	import spq_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire spq_in_t cmd,
	output logic         done,
	output spq_out_t     rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic [CW+7:0] count_ext;
	logic          fire;
	logic          full;
	logic          empty;
	logic          enq_ok;
	logic          deq_ok;
	spq_ctrl_t     ctrl;
	spq_entry_t    new_entry;
	spq_out_t      rsp_q;
	logic          done_q;

	// cell state and neighbor links
	spq_entry_t    ents [DEPTH];
	logic [DEPTH-1:0] shifts;

	// no word is ever held back, so busy is tied low
	assign busy = 1'b0;
	assign fire = start && !busy;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign enq_ok = fire && (cmd.action == ACT_ENQ) && !full;
	assign deq_ok = fire && (cmd.action == ACT_DEQ) && !empty;

	assign ctrl.enq = enq_ok;
	assign ctrl.deq = deq_ok;

	assign new_entry.value = cmd.value;
	assign new_entry.prio  = cmd.priority_req;

	always_comb begin
		count_next = count_q;
		if (enq_ok) begin
			count_next = count_q + CW'(1);
		end else if (deq_ok) begin
			count_next = count_q - CW'(1);
		end
	end

	// count port is the low eight bits
	assign count_ext = {8'b0, count_next};

	// the chain: cell 0 is the head, inserts ripple toward the tail
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic       occ;
		logic       pshift;
		spq_entry_t pent;
		spq_entry_t nent;

		assign occ = (count_q > CW'(i));

		if (i == 0) begin : g_head
			assign pshift = 1'b0;
			assign pent   = new_entry;
		end else begin : g_body
			assign pshift = shifts[i-1];
			assign pent   = ents[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign nent = ents[i];
		end else begin : g_mid
			assign nent = ents[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (occ),
			.new_entry  (new_entry),
			.prev_entry (pent),
			.prev_shift (pshift),
			.next_entry (nent),
			.shift      (shifts[i]),
			.entry      (ents[i])
		);
	end

	// entry count and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= fire;
		end
	end

	// result word, head taken from cell 0 before it shifts
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.head_valid    <= deq_ok;
			rsp_q.head_value    <= deq_ok ? ents[0].value : 32'sd0;
			rsp_q.head_priority <= deq_ok ? ents[0].prio : 16'sd0;
			rsp_q.count         <= count_ext[7:0];
			if (cmd.action == ACT_ENQ) begin
				rsp_q.status <= full ? ST_OVERFLOW : ST_OK;
			end else begin
				rsp_q.status <= empty ? ST_UNDERFLOW : ST_OK;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire
